/* rtl/core/evd_pkg.sv */
`timescale 1ns / 1ps
// Types and constants shared by the escaped varint decoder modules.
package evd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned PART_W  = 24;

	// Lead bytes that announce a longer payload (-128 and -127 as signed bytes).
	localparam logic [BYTE_W-1:0] LEAD_SHORT = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD_LONG  = 8'h81;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_SHORT = 2'd1,
		PH_LONG  = 2'd2
	} phase_t;

	// Input stage contents handed to the decoder.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} byte_slot_t;

	// What the decoder makes of the byte in the input stage.
	typedef struct packed {
		logic               produce;
		logic [VALUE_W-1:0] value;
	} dec_result_t;

endpackage

/* rtl/core/evd_in_reg.sv */
`timescale 1ns / 1ps
// Input register stage: holds one accepted byte until the decoder takes it.
module evd_in_reg
	import evd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              advance,
	output byte_slot_t        slot
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              load;

	// The stage can take a new byte when it is empty or is being emptied.
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= in_byte;
		end
	end

	assign slot.valid = valid_s1;
	assign slot.data  = byte_s1;

endmodule

/* rtl/core/evd_decode.sv */
`timescale 1ns / 1ps
// Decoder state and single-pass decode of the byte held in the input stage.
module evd_decode
	import evd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  byte_slot_t  slot,
	input  logic        advance,
	output dec_result_t result
);

	phase_t            phase_q, phase_d;
	logic [1:0]        seen_q, seen_d;
	logic [PART_W-1:0] part_q, part_d;
	logic [BYTE_W-1:0] b;

	assign b = slot.data;

	always_comb begin
		phase_d        = phase_q;
		seen_d         = seen_q;
		part_d         = part_q;
		result.produce = 1'b0;
		result.value   = {{(VALUE_W-BYTE_W){b[BYTE_W-1]}}, b};
		unique case (phase_q)
			PH_SHORT: begin
				if (seen_q == 2'd0) begin
					part_d = {{(PART_W-BYTE_W){1'b0}}, b};
					seen_d = 2'd1;
				end else begin
					result.produce = 1'b1;
					result.value   = {{(VALUE_W-2*BYTE_W){b[BYTE_W-1]}}, b, part_q[BYTE_W-1:0]};
					phase_d        = PH_IDLE;
					seen_d         = 2'd0;
					part_d         = '0;
				end
			end
			PH_LONG: begin
				case (seen_q)
					2'd0: begin
						part_d[7:0] = b;
						seen_d      = 2'd1;
					end
					2'd1: begin
						part_d[15:8] = b;
						seen_d       = 2'd2;
					end
					2'd2: begin
						part_d[23:16] = b;
						seen_d        = 2'd3;
					end
					default: begin
						result.produce = 1'b1;
						result.value   = {b, part_q};
						phase_d        = PH_IDLE;
						seen_d         = 2'd0;
						part_d         = '0;
					end
				endcase
			end
			default: begin
				// Lead byte; the unused phase code behaves the same way.
				seen_d = 2'd0;
				part_d = '0;
				if (b == LEAD_SHORT) begin
					phase_d = PH_SHORT;
				end else if (b == LEAD_LONG) begin
					phase_d = PH_LONG;
				end else begin
					phase_d        = PH_IDLE;
					result.produce = 1'b1;
				end
			end
		endcase
		if (!slot.valid) begin
			result.produce = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			seen_q  <= 2'd0;
			part_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			seen_q  <= seen_d;
			part_q  <= part_d;
		end
	end

endmodule

/* rtl/core/evd_out_reg.sv */
`timescale 1ns / 1ps
// Result register: holds a decoded value until the receiver takes it.
module evd_out_reg
	import evd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  byte_slot_t                slot,
	input  dec_result_t               result,
	output logic                      advance,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] value
);

	logic               valid_q;
	logic [VALUE_W-1:0] value_q;
	logic               free;

	// The register is free when empty or when its value leaves this cycle.
	assign free    = !valid_q || !out_stall;
	// A byte that completes nothing never needs the result register.
	assign advance = slot.valid && (free || !result.produce);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= advance && result.produce;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.produce) begin
			value_q <= result.value;
		end
	end

	assign out_valid = valid_q;
	assign value     = value_q;

endmodule

/* rtl/core/escaped_varint_decoder.sv */
`timescale 1ns / 1ps
// Top level of the escaped varint decoder.
//
// The input channel (in_valid, in_stall, in_byte) carries one byte of the encoded
// stream per item. A byte of 0x80 opens a two-byte payload (low byte first, high
// byte sign-extended), 0x81 opens a four-byte little-endian payload, and any other
// lead byte is itself the value, sign-extended. The output channel (out_valid,
// out_stall, value) carries one signed 32-bit value per item, only when the byte
// that completes a value has been decoded. Bytes are taken on an edge where valid
// is high and stall is low.
// The completing byte passes through the input register, then the result register,
// before value is shown. Throughput is one byte per cycle unless a completing byte
// meets a full, stalled result register: the input register refills each cycle,
// the decode is combinational, and the result register is reloaded as it empties.
// A reset empties both registers and returns the decoder to waiting for a lead
// byte. While the receiver stalls, the value holds; bytes that complete nothing
// keep flowing, and in_stall rises only when a completing byte meets a full,
// stalled result register.
module escaped_varint_decoder
	import evd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [BYTE_W-1:0]         in_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] value
);

	byte_slot_t  slot;
	dec_result_t result;
	logic        advance;

	evd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.advance  (advance),
		.slot     (slot)
	);

	evd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.slot    (slot),
		.advance (advance),
		.result  (result)
	);

	evd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.slot      (slot),
		.result    (result),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value)
	);

endmodule

/* rtl/core/evd_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the escaped varint decoder, bound to the top level.
module evd_checker
	import evd_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [VALUE_W-1:0] value
);

	// A stalled result stays and keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value))
		else $error("stalled result changed or vanished");

	// The input side is held back only by a full, stalled result register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// With no result shown and no byte taken, no result can appear next cycle.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(in_valid && !in_stall) |=> !out_valid)
		else $error("result appeared without an accepted byte");

endmodule

bind escaped_varint_decoder evd_checker u_evd_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the escaped varint decoder, with a byte driver and a value monitor.
module tb;
	import evd_pkg::*;

	// Clock, reset and the two channels of the block.
	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic [BYTE_W-1:0]         in_byte   = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [VALUE_W-1:0] value;

	// Bytes still to be offered, and the decoded values still to arrive, oldest first.
	logic [BYTE_W-1:0]  pending_bytes[$];
	logic [VALUE_W-1:0] values_due[$];

	// The testbench's own copy of the decoder state.
	phase_t             dec_phase;
	logic [1:0]         dec_count;
	logic [PART_W-1:0]  dec_partial;

	// Set at each rising edge when the byte on the bus was taken by the block.
	logic               byte_taken = 1'b0;

	// Cycle counters kept separately by the sender and the receiver.
	int unsigned        send_cycle = 0;
	int unsigned        recv_cycle = 0;
	int unsigned        faults     = 0;

	escaped_varint_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Counts a failure. Only the first ten are described in full; the rest are just counted.
	function automatic void note_fault(input string what);
		faults++;
		if (faults <= 10) begin
			$display("ERROR at %0t ns: %s", $realtime, what);
		end
	endfunction

	// Predicts what one accepted byte does to the decoder. A lead byte either gives a value
	// of its own, sign-extended, or opens a two- or four-byte payload. Inside a payload every
	// byte is data, so the escape codes are never taken as lead bytes there.
	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		case (dec_phase)
			PH_SHORT: begin
				if (dec_count == 2'd0) begin
					dec_partial = {16'd0, b};
					dec_count   = 2'd1;
				end else begin
					values_due.push_back({{16{b[7]}}, b, dec_partial[7:0]});
					dec_phase   = PH_IDLE;
					dec_count   = 2'd0;
					dec_partial = '0;
				end
			end
			PH_LONG: begin
				if (dec_count < 2'd3) begin
					dec_partial = dec_partial | (PART_W'(b) << (8 * dec_count));
					dec_count   = dec_count + 2'd1;
				end else begin
					values_due.push_back({b, dec_partial});
					dec_phase   = PH_IDLE;
					dec_count   = 2'd0;
					dec_partial = '0;
				end
			end
			default: begin
				// Waiting for a lead byte; the unused phase code is treated the same way.
				dec_count   = 2'd0;
				dec_partial = '0;
				if (b == LEAD_SHORT) begin
					dec_phase = PH_SHORT;
				end else if (b == LEAD_LONG) begin
					dec_phase = PH_LONG;
				end else begin
					dec_phase = PH_IDLE;
					values_due.push_back({{24{b[7]}}, b});
				end
			end
		endcase
	endfunction

	// Queues a well-formed two-byte payload value, low byte first.
	function automatic void queue_short(input logic [15:0] v);
		pending_bytes.push_back(LEAD_SHORT);
		pending_bytes.push_back(v[7:0]);
		pending_bytes.push_back(v[15:8]);
	endfunction

	// Queues a well-formed four-byte payload value, little-endian.
	function automatic void queue_long(input logic [31:0] v);
		pending_bytes.push_back(LEAD_LONG);
		for (int k = 0; k < 4; k++) begin
			pending_bytes.push_back(v[8*k +: 8]);
		end
	endfunction

	// Sender. The next byte is put on the bus at a falling edge once the previous one has been
	// taken, so a stalled byte stays put with valid held high. It rests at random, with odds of 28 in a
	// hundred, except for a stretch in the middle of the run where the sender never pauses.
	always @(negedge clk) begin
		logic rest;
		if (arst_n) begin
			send_cycle <= send_cycle + 1;
			rest = (send_cycle >= 1200 && send_cycle < 1600) ? 1'b0
				: ($urandom_range(99) < 28);
			if (!in_valid || byte_taken) begin
				if (pending_bytes.size() > 0 && !rest) begin
					in_byte  <= pending_bytes.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. It stalls at random, with odds of 28 in a hundred, not at all during the same quiet
	// stretch, and holds off unbroken through a stretch early on, while the sender carries
	// on offering bytes, so that the result register fills and the block stalls its input.
	always @(negedge clk) begin
		if (arst_n) begin
			recv_cycle <= recv_cycle + 1;
			if (recv_cycle >= 600 && recv_cycle < 700) begin
				out_stall <= 1'b1;
			end else if (recv_cycle >= 1200 && recv_cycle < 1600) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 28);
			end
		end
	end

	// Monitor. Every byte taken at this edge goes through the predictor first, then any value
	// taken at this edge is compared with the oldest one still due.
	always @(posedge clk) begin
		logic [VALUE_W-1:0] due;
		if (arst_n) begin
			byte_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				decode_byte(in_byte);
			end
			if (out_valid && !out_stall) begin
				if (values_due.size() == 0) begin
					note_fault($sformatf("value %0d arrived with none due", value));
				end else begin
					due = values_due.pop_front();
					if (value !== due) begin
						note_fault($sformatf("value: expected %0d (0x%08h), got %0d (0x%08h)",
							$signed(due), due, value, value));
					end
				end
			end
		end
	end

	// Stimulus and the end of the run.
	initial begin
		int unsigned pick;
		dec_phase   = PH_IDLE;
		dec_count   = 2'd0;
		dec_partial = '0;

		// Single-byte values on both sides of zero, the most positive, and one next to the codes.
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'h7f);
		pending_bytes.push_back(8'hff);
		pending_bytes.push_back(8'h82);
		// Short payloads: the most negative, the most positive, and escape codes as data.
		queue_short(16'h8000);
		queue_short(16'h7fff);
		queue_short({LEAD_LONG, LEAD_SHORT});
		// Long payloads: the most negative, the most positive, and escape codes as data.
		queue_long(32'h8000_0000);
		queue_long(32'h7fff_ffff);
		queue_long({LEAD_SHORT, LEAD_LONG, LEAD_SHORT, LEAD_LONG});

		// Random part: mostly well-formed values with random content, some raw noise bytes.
		// Since the decoder only counts bytes, noise just shifts the framing of what follows.
		while (pending_bytes.size() < 1825) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				pending_bytes.push_back(8'($urandom_range(255)));
			end else if (pick < 62) begin
				queue_short(16'($urandom));
			end else if (pick < 90) begin
				queue_long($urandom);
			end else begin
				repeat ($urandom_range(3, 1)) pending_bytes.push_back(8'($urandom_range(255)));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every byte has been taken and every due value has come out.
		while (pending_bytes.size() > 0 || in_valid) @(posedge clk);
		while (values_due.size() > 0) @(posedge clk);
		// Keep running to catch stray results.
		repeat (10) @(posedge clk);

		if (values_due.size() > 0) begin
			note_fault($sformatf("%0d values never arrived", values_due.size()));
		end
		if (faults == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// Guard against a hang: far longer than the slowest correct run needs.
	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
